@@ design/mbf_pkg.sv @@
// Shared types and constants for the metaball field and normal block.
`timescale 1ns / 1ps

package mbf_pkg;

    // Field widths of the item and of the configuration registers
    localparam int COORD_W    = 16;
    localparam int R2_W       = 24;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Datapath widths
    localparam int AV_W  = 16;          // |vertex - centre|
    localparam int SQ_W  = 2 * AV_W;    // one squared component
    localparam int PN_W  = AV_W + R2_W; // |v| * r2
    localparam int D2_W  = 34;          // sum of three squares
    localparam int DEN_W = 2 * D2_W;    // d2 squared

    // Quotient bits resolved by the division chain; larger terms clip
    localparam int QBITS = 47;

    localparam int NUM_BALLS = 2;
    localparam int NUM_AXES  = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BALL_A_X  = 3'd0,
        CFG_BALL_A_Y  = 3'd1,
        CFG_BALL_A_Z  = 3'd2,
        CFG_BALL_A_R2 = 3'd3,
        CFG_BALL_B_X  = 3'd4,
        CFG_BALL_B_Y  = 3'd5,
        CFG_BALL_B_Z  = 3'd6,
        CFG_BALL_B_R2 = 3'd7
    } cfg_reg_e;

    // Side information that travels with each division
    typedef struct packed {
        logic ovf;  // quotient does not fit in QBITS
        logic neg;  // offset component was negative
    } mbf_tag_t;

endpackage

@@ design/mbf_cell.sv @@
// One restoring division step: resolves one quotient bit and hands on.
`timescale 1ns / 1ps

module mbf_cell #(
    parameter int DW = 34
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [DW-1:0]               rem_in,
    input  logic [DW-1:0]               den_in,
    input  logic [mbf_pkg::QBITS-1:0]   nq_in,
    input  mbf_pkg::mbf_tag_t           tag_in,
    output logic [DW-1:0]               rem_out,
    output logic [DW-1:0]               den_out,
    output logic [mbf_pkg::QBITS-1:0]   nq_out,
    output mbf_pkg::mbf_tag_t           tag_out
);

    logic [DW:0]                trial;
    logic [DW:0]                diff;
    logic                       ge;
    logic [DW-1:0]              rem_next;
    logic [mbf_pkg::QBITS-1:0]  nq_next;
    logic [DW-1:0]              rem_reg;
    logic [DW-1:0]              den_reg;
    logic [mbf_pkg::QBITS-1:0]  nq_reg;
    mbf_pkg::mbf_tag_t          tag_reg;

    // Shift in the next numerator bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_in, nq_in[mbf_pkg::QBITS-1]};
        diff     = trial - {1'b0, den_in};
        ge       = (trial >= {1'b0, den_in});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        nq_next  = {nq_in[mbf_pkg::QBITS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            nq_reg  <= nq_next;
            tag_reg <= tag_in;
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign nq_out  = nq_reg;
    assign tag_out = tag_reg;

endmodule

@@ design/mbf_lane.sv @@
// A chain of division cells producing one QBITS-bit quotient per item.
`timescale 1ns / 1ps

module mbf_lane #(
    parameter int DW = 34
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [DW-1:0]               rem_in,
    input  logic [DW-1:0]               den_in,
    input  logic [mbf_pkg::QBITS-1:0]   nq_in,
    input  mbf_pkg::mbf_tag_t           tag_in,
    output logic [mbf_pkg::QBITS-1:0]   quo,
    output mbf_pkg::mbf_tag_t           tag_out
);

    logic [DW-1:0]              rem_w [mbf_pkg::QBITS+1];
    logic [DW-1:0]              den_w [mbf_pkg::QBITS+1];
    logic [mbf_pkg::QBITS-1:0]  nq_w  [mbf_pkg::QBITS+1];
    mbf_pkg::mbf_tag_t          tag_w [mbf_pkg::QBITS+1];

    assign rem_w[0] = rem_in;
    assign den_w[0] = den_in;
    assign nq_w[0]  = nq_in;
    assign tag_w[0] = tag_in;

    // One cell per quotient bit, most significant first
    for (genvar i = 0; i < mbf_pkg::QBITS; i++)
    begin : g_cell
        mbf_cell #(.DW(DW)) u_cell (
            .clk     (clk),
            .en      (en),
            .rem_in  (rem_w[i]),
            .den_in  (den_w[i]),
            .nq_in   (nq_w[i]),
            .tag_in  (tag_w[i]),
            .rem_out (rem_w[i+1]),
            .den_out (den_w[i+1]),
            .nq_out  (nq_w[i+1]),
            .tag_out (tag_w[i+1])
        );
    end

    assign quo     = nq_w[mbf_pkg::QBITS];
    assign tag_out = tag_w[mbf_pkg::QBITS];

endmodule

@@ design/metaball_field_and_normal.sv @@
// Top level: two-ball metaball field and normal, one vertex item per cycle unless the output stalls.
`timescale 1ns / 1ps

// Takes one vertex item per clock and returns the summed field r2/d2 of two
// configured balls in Q8.24 and normal v*r2/d2^2 scaled by 2^(16+2*FRAC_BITS),
// with saturation and a clip flag. Five front stages form the offsets, squares,
// d2 (a zero d2 counts as one LSB), d2^2 and the division set-up; then each of
// the eight divisions runs down its own chain of 47 cells, one quotient bit per
// cell, and a final register sums and saturates. The whole pipeline advances
// together and only holds while a finished result is stalled at the output, so
// a full stream runs at one item per cycle. The user must write ball registers
// with cfg_we only while no items are in flight; the block does not enforce it.
module metaball_field_and_normal #(
    parameter int FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [mbf_pkg::COORD_W-1:0] vertex_x,
    input  logic signed [mbf_pkg::COORD_W-1:0] vertex_y,
    input  logic signed [mbf_pkg::COORD_W-1:0] vertex_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mbf_pkg::OUT_W-1:0]         field_value,
    output logic signed [mbf_pkg::OUT_W-1:0]  normal_x,
    output logic signed [mbf_pkg::OUT_W-1:0]  normal_y,
    output logic signed [mbf_pkg::OUT_W-1:0]  normal_z,
    output logic                              saturated
);

    localparam int FSH   = 16 + FRAC_BITS;
    localparam int NSH   = 16 + 2 * FRAC_BITS;
    localparam int QB    = mbf_pkg::QBITS;
    localparam int FN_W  = mbf_pkg::R2_W + FSH + QB;
    localparam int NN_W  = mbf_pkg::PN_W + NSH;
    localparam int NHI_W = NN_W - QB;
    localparam int NV    = 5 + QB;
    localparam int NB    = mbf_pkg::NUM_BALLS;
    localparam int NA    = mbf_pkg::NUM_AXES;
    localparam int CW    = mbf_pkg::COORD_W;
    localparam int AVW   = mbf_pkg::AV_W;
    localparam int D2W   = mbf_pkg::D2_W;
    localparam int DENW  = mbf_pkg::DEN_W;
    localparam int OW    = mbf_pkg::OUT_W;

    // Configuration registers
    logic [CW-1:0]             cx_reg [NB][NA];
    logic [mbf_pkg::R2_W-1:0]  r2_reg [NB];

    // Pipeline control
    logic            adv;
    logic [NV-1:0]   vld_reg;
    logic            out_valid_reg;

    // Front stages
    logic [CW-1:0]             vert [NA];
    logic [AVW-1:0]            av_next [NB][NA];
    logic                      neg_next [NB][NA];
    logic [AVW-1:0]            av_reg [NB][NA];
    logic                      s1_neg_reg [NB][NA];
    logic [mbf_pkg::SQ_W-1:0]  sq_reg [NB][NA];
    logic [mbf_pkg::PN_W-1:0]  s2_pn_reg [NB][NA];
    logic                      s2_neg_reg [NB][NA];
    logic [D2W-1:0]            d2_next [NB];
    logic [D2W-1:0]            s3_d2_reg [NB];
    logic [mbf_pkg::PN_W-1:0]  s3_pn_reg [NB][NA];
    logic                      s3_neg_reg [NB][NA];
    logic [D2W-1:0]            s4_d2_reg [NB];
    logic [DENW-1:0]           s4_den_reg [NB];
    logic [mbf_pkg::PN_W-1:0]  s4_pn_reg [NB][NA];
    logic                      s4_neg_reg [NB][NA];

    // Division set-up stage
    logic [FN_W-1:0]           fn [NB];
    logic [D2W-1:0]            fhi [NB];
    logic [NN_W-1:0]           nn [NB][NA];
    logic [DENW-1:0]           nhi [NB][NA];
    logic [D2W-1:0]            f_rem_reg [NB];
    logic [D2W-1:0]            f_den_reg [NB];
    logic [QB-1:0]             f_nq_reg [NB];
    mbf_pkg::mbf_tag_t         f_tag_reg [NB];
    logic [DENW-1:0]           n_rem_reg [NB][NA];
    logic [DENW-1:0]           n_den_reg [NB][NA];
    logic [QB-1:0]             n_nq_reg [NB][NA];
    mbf_pkg::mbf_tag_t         n_tag_reg [NB][NA];

    // Lane results
    logic [QB-1:0]             f_quo [NB];
    mbf_pkg::mbf_tag_t         f_tag_out [NB];
    logic [QB-1:0]             n_quo [NB][NA];
    mbf_pkg::mbf_tag_t         n_tag_out [NB][NA];

    // Output stage
    logic [QB:0]               fsum;
    logic                      fsat;
    logic [QB-1:0]             nmag [NB];
    logic [QB+1:0]             nsgn [NB];
    logic [QB+2:0]             nsum;
    logic                      sat_hi;
    logic                      sat_lo;
    logic [OW-1:0]             field_next;
    logic [OW-1:0]             normal_next [NA];
    logic                      clip_next;
    logic [OW-1:0]             field_reg;
    logic [OW-1:0]             normal_reg [NA];
    logic                      saturated_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg[0][0] <= 16'hFE00;
            cx_reg[0][1] <= 16'h0200;
            cx_reg[0][2] <= 16'h0000;
            r2_reg[0]    <= 24'd2304;
            cx_reg[1][0] <= 16'h0200;
            cx_reg[1][1] <= 16'h0180;
            cx_reg[1][2] <= 16'h0000;
            r2_reg[1]    <= 24'd4096;
        end
        else if (cfg_we)
        begin
            unique case (mbf_pkg::cfg_reg_e'(cfg_index))
                mbf_pkg::CFG_BALL_A_X:  cx_reg[0][0] <= cfg_data[CW-1:0];
                mbf_pkg::CFG_BALL_A_Y:  cx_reg[0][1] <= cfg_data[CW-1:0];
                mbf_pkg::CFG_BALL_A_Z:  cx_reg[0][2] <= cfg_data[CW-1:0];
                mbf_pkg::CFG_BALL_A_R2: r2_reg[0]    <= cfg_data;
                mbf_pkg::CFG_BALL_B_X:  cx_reg[1][0] <= cfg_data[CW-1:0];
                mbf_pkg::CFG_BALL_B_Y:  cx_reg[1][1] <= cfg_data[CW-1:0];
                mbf_pkg::CFG_BALL_B_Z:  cx_reg[1][2] <= cfg_data[CW-1:0];
                mbf_pkg::CFG_BALL_B_R2: r2_reg[1]    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits through the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[NV-2:0], in_valid};
            out_valid_reg <= vld_reg[NV-1];
        end
    end

    // Stage 1: offsets and their magnitudes
    assign vert[0] = vertex_x;
    assign vert[1] = vertex_y;
    assign vert[2] = vertex_z;

    always_comb
    begin
        logic [CW:0] v;
        logic [CW:0] a;
        for (int b = 0; b < NB; b++)
        begin
            for (int c = 0; c < NA; c++)
            begin
                v = {vert[c][CW-1], vert[c]} - {cx_reg[b][c][CW-1], cx_reg[b][c]};
                a = v[CW] ? (~v + 1'b1) : v;
                av_next[b][c]  = a[AVW-1:0];
                neg_next[b][c] = v[CW];
            end
        end
    end

    // Stage 3 sum of squares, with a zero distance taken as one LSB
    always_comb
    begin
        logic [D2W-1:0] s;
        for (int b = 0; b < NB; b++)
        begin
            s = D2W'(sq_reg[b][0]) + D2W'(sq_reg[b][1]) + D2W'(sq_reg[b][2]);
            d2_next[b] = (s == '0) ? D2W'(1) : s;
        end
    end

    // Numerators split into a leading part and the bits fed to the cells
    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            fn[b]  = FN_W'(r2_reg[b]) << FSH;
            fhi[b] = fn[b][QB+D2W-1:QB];
            for (int c = 0; c < NA; c++)
            begin
                nn[b][c]  = NN_W'(s4_pn_reg[b][c]) << NSH;
                nhi[b][c] = {{(DENW-NHI_W){1'b0}}, nn[b][c][NN_W-1:QB]};
            end
        end
    end

    // Front pipeline registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int b = 0; b < NB; b++)
            begin
                s3_d2_reg[b]  <= d2_next[b];
                s4_d2_reg[b]  <= s3_d2_reg[b];
                s4_den_reg[b] <= DENW'(s3_d2_reg[b]) * DENW'(s3_d2_reg[b]);
                f_rem_reg[b]  <= fhi[b];
                f_den_reg[b]  <= s4_d2_reg[b];
                f_nq_reg[b]   <= fn[b][QB-1:0];
                f_tag_reg[b]  <= '{ovf: (fhi[b] >= s4_d2_reg[b]), neg: 1'b0};
                for (int c = 0; c < NA; c++)
                begin
                    av_reg[b][c]     <= av_next[b][c];
                    s1_neg_reg[b][c] <= neg_next[b][c];
                    sq_reg[b][c]     <= mbf_pkg::SQ_W'(av_reg[b][c])
                                        * mbf_pkg::SQ_W'(av_reg[b][c]);
                    s2_pn_reg[b][c]  <= mbf_pkg::PN_W'(av_reg[b][c])
                                        * mbf_pkg::PN_W'(r2_reg[b]);
                    s2_neg_reg[b][c] <= s1_neg_reg[b][c];
                    s3_pn_reg[b][c]  <= s2_pn_reg[b][c];
                    s3_neg_reg[b][c] <= s2_neg_reg[b][c];
                    s4_pn_reg[b][c]  <= s3_pn_reg[b][c];
                    s4_neg_reg[b][c] <= s3_neg_reg[b][c];
                    n_rem_reg[b][c]  <= nhi[b][c];
                    n_den_reg[b][c]  <= s4_den_reg[b];
                    n_nq_reg[b][c]   <= nn[b][c][QB-1:0];
                    n_tag_reg[b][c]  <= '{ovf: (nhi[b][c] >= s4_den_reg[b]),
                                          neg: s4_neg_reg[b][c]};
                end
            end
        end
    end

    // Division chains: one field lane and three normal lanes per ball
    for (genvar b = 0; b < NB; b++)
    begin : g_ball
        mbf_lane #(.DW(D2W)) u_field (
            .clk     (clk),
            .en      (adv),
            .rem_in  (f_rem_reg[b]),
            .den_in  (f_den_reg[b]),
            .nq_in   (f_nq_reg[b]),
            .tag_in  (f_tag_reg[b]),
            .quo     (f_quo[b]),
            .tag_out (f_tag_out[b])
        );
        for (genvar c = 0; c < NA; c++)
        begin : g_axis
            mbf_lane #(.DW(DENW)) u_normal (
                .clk     (clk),
                .en      (adv),
                .rem_in  (n_rem_reg[b][c]),
                .den_in  (n_den_reg[b][c]),
                .nq_in   (n_nq_reg[b][c]),
                .tag_in  (n_tag_reg[b][c]),
                .quo     (n_quo[b][c]),
                .tag_out (n_tag_out[b][c])
            );
        end
    end

    // Output stage: sum the two balls and saturate
    always_comb
    begin
        fsum = {1'b0, f_quo[0]} + {1'b0, f_quo[1]};
        fsat = f_tag_out[0].ovf || f_tag_out[1].ovf || (fsum[QB:OW] != '0);
        field_next = fsat ? {OW{1'b1}} : fsum[OW-1:0];
        clip_next  = fsat;
        for (int c = 0; c < NA; c++)
        begin
            for (int b = 0; b < NB; b++)
            begin
                nmag[b] = n_tag_out[b][c].ovf ? {QB{1'b1}} : n_quo[b][c];
                nsgn[b] = n_tag_out[b][c].neg ? ((QB+2)'(0) - {2'b00, nmag[b]})
                                              : {2'b00, nmag[b]};
                if (n_tag_out[b][c].ovf)
                    clip_next = 1'b1;
            end
            nsum   = {nsgn[0][QB+1], nsgn[0]} + {nsgn[1][QB+1], nsgn[1]};
            sat_hi = !nsum[QB+2] && (nsum[QB+1:OW-1] != '0);
            sat_lo =  nsum[QB+2] && (nsum[QB+1:OW-1] != '1);
            if (sat_hi)
                normal_next[c] = {1'b0, {(OW-1){1'b1}}};
            else if (sat_lo)
                normal_next[c] = {1'b1, {(OW-1){1'b0}}};
            else
                normal_next[c] = nsum[OW-1:0];
            if (sat_hi || sat_lo)
                clip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            field_reg     <= field_next;
            saturated_reg <= clip_next;
            for (int c = 0; c < NA; c++)
                normal_reg[c] <= normal_next[c];
        end
    end

    assign out_valid   = out_valid_reg;
    assign field_value = field_reg;
    assign normal_x    = normal_reg[0];
    assign normal_y    = normal_reg[1];
    assign normal_z    = normal_reg[2];
    assign saturated   = saturated_reg;

`ifndef ASSERT_OFF
    // An accepted item enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    // The pipeline freezes while the output is stalled
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    // A clipped x normal term of the first ball raises the flag
    a_ovf_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_reg[NV-1] && n_tag_out[0][0].ovf) |=> (out_valid && saturated))
        else $error("clipped normal term without saturated flag");
`endif

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the two-ball metaball field and normal block.
`timescale 1ns / 1ps

module tb;

    localparam longint unsigned NORM_TERM_MAX = 64'h7FFF_FFFF_FFFF;
    localparam int DRAIN_CYCLES = 60;   // pipeline latency plus margin
    localparam int STALL_LIMIT  = 20000;
    localparam int OW  = mbf_pkg::OUT_W;
    localparam int CRW = mbf_pkg::COORD_W;
    localparam int CDW = mbf_pkg::CFG_DATA_W;
    localparam int NB  = mbf_pkg::NUM_BALLS;
    localparam int NA  = mbf_pkg::NUM_AXES;

    typedef struct {
        logic [OW-1:0]        field;
        logic signed [OW-1:0] nx;
        logic signed [OW-1:0] ny;
        logic signed [OW-1:0] nz;
        logic                 sat;
    } field_sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [mbf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [CDW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CRW-1:0] vertex_x = '0;
    logic signed [CRW-1:0] vertex_y = '0;
    logic signed [CRW-1:0] vertex_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [OW-1:0] field_value;
    logic signed [OW-1:0] normal_x, normal_y, normal_z;
    logic saturated;

    // Local copy of the ball registers
    logic signed [CRW-1:0]        ball_centre [NB][NA];
    logic [mbf_pkg::R2_W-1:0]     ball_r2 [NB];

    field_sample_t expected_samples[$];
    int err_cnt = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    metaball_field_and_normal u_top (.*);

    // Field and normal of both balls at one vertex
    function automatic field_sample_t field_and_normal_of(logic signed [CRW-1:0] px,
                                                          logic signed [CRW-1:0] py,
                                                          logic signed [CRW-1:0] pz);
        field_sample_t res;
        int vert[NA];
        int off[NA];
        longint unsigned mag[NA];
        longint unsigned d2, field, r2;
        longint nsum[NA];
        logic [127:0] num, den, quo;
        longint term;
        bit clip;
        vert[0] = px; vert[1] = py; vert[2] = pz;
        field = 0; clip = 0;
        for (int c = 0; c < NA; c++) nsum[c] = 0;
        for (int b = 0; b < NB; b++)
        begin
            r2 = ball_r2[b];
            d2 = 0;
            for (int c = 0; c < NA; c++)
            begin
                off[c] = vert[c] - int'(ball_centre[b][c]);
                mag[c] = (off[c] < 0) ? -off[c] : off[c];
                d2 += mag[c] * mag[c];
            end
            if (d2 == 0) d2 = 1;   // vertex on the centre
            field += (r2 << (16 + 8)) / d2;
            for (int c = 0; c < NA; c++)
            begin
                num = (128'(mag[c]) * 128'(r2)) << 32;
                den = 128'(d2) * 128'(d2);
                quo = num / den;
                if (quo > 128'(NORM_TERM_MAX))
                begin
                    quo = 128'(NORM_TERM_MAX);
                    clip = 1;
                end
                term = longint'(quo[63:0]);
                nsum[c] += (off[c] < 0) ? -term : term;
            end
        end
        if (field > 64'hFFFF_FFFF)
        begin
            field = 64'hFFFF_FFFF;
            clip = 1;
        end
        for (int c = 0; c < NA; c++)
        begin
            if (nsum[c] > 64'sd2147483647)
            begin
                nsum[c] = 64'sd2147483647;
                clip = 1;
            end
            else if (nsum[c] < -64'sd2147483648)
            begin
                nsum[c] = -64'sd2147483648;
                clip = 1;
            end
        end
        res.field = field[31:0];
        res.nx = nsum[0][31:0];
        res.ny = nsum[1][31:0];
        res.nz = nsum[2][31:0];
        res.sat = clip;
        return res;
    endfunction

    // Receiver back-pressure
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("unexpected result item: field %h", field_value);
                err_cnt++;
            end
            else
            begin
                field_sample_t e;
                e = expected_samples.pop_front();
                if (field_value !== e.field)
                begin
                    $error("field_value expected %h actual %h", e.field, field_value);
                    err_cnt++;
                end
                if (normal_x !== e.nx)
                begin
                    $error("normal_x expected %h actual %h", e.nx, normal_x);
                    err_cnt++;
                end
                if (normal_y !== e.ny)
                begin
                    $error("normal_y expected %h actual %h", e.ny, normal_y);
                    err_cnt++;
                end
                if (normal_z !== e.nz)
                begin
                    $error("normal_z expected %h actual %h", e.nz, normal_z);
                    err_cnt++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated expected %b actual %b", e.sat, saturated);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: cycles with no item accepted on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Send one vertex item; valid stays high afterwards until the next negedge
    task automatic send_vertex(logic signed [CRW-1:0] px,
                               logic signed [CRW-1:0] py,
                               logic signed [CRW-1:0] pz);
        bit done;
        @(negedge clk);
        // Idle one cycle at a time with the sender's idling share
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        vertex_x <= px;
        vertex_y <= py;
        vertex_z <= pz;
        done = 0;
        while (!done)
        begin
            @(posedge clk);
            if (!in_stall)
            begin
                expected_samples.push_back(field_and_normal_of(px, py, pz));
                done = 1;
            end
        end
    endtask

    // Hold off until every expected result has come and the pipe is empty
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        wait (expected_samples.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(mbf_pkg::cfg_reg_e idx, logic [CDW-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == mbf_pkg::CFG_BALL_A_R2 || idx == mbf_pkg::CFG_BALL_B_R2)
            ball_r2[idx[2]] = val;
        else
            ball_centre[idx[2]][idx[1:0]] = val[15:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_balls(int ax, int ay, int az, int ar, int bx, int by, int bz, int br);
        write_reg(mbf_pkg::CFG_BALL_A_X, CDW'(ax));
        write_reg(mbf_pkg::CFG_BALL_A_Y, CDW'(ay));
        write_reg(mbf_pkg::CFG_BALL_A_Z, CDW'(az));
        write_reg(mbf_pkg::CFG_BALL_A_R2, CDW'(ar));
        write_reg(mbf_pkg::CFG_BALL_B_X, CDW'(bx));
        write_reg(mbf_pkg::CFG_BALL_B_Y, CDW'(by));
        write_reg(mbf_pkg::CFG_BALL_B_Z, CDW'(bz));
        write_reg(mbf_pkg::CFG_BALL_B_R2, CDW'(br));
    endtask

    // Reset defaults: coordinate extremes and points around the balls
    task automatic test_default_balls;
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
        send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_vertex(16'sh8000, 16'sh7FFF, 16'sh0000);
        send_vertex(16'sh0000, 16'sh0000, 16'sh0000);
        send_vertex(-16'sd512, 16'sd512, 16'sd0);    // on the first centre
        send_vertex(16'sd512, 16'sd384, 16'sd0);     // on the second centre
        send_vertex(-16'sd511, 16'sd512, 16'sd0);    // one LSB off a centre
        send_vertex(16'sh5555, 16'shAAAA, 16'sh1234);
        send_vertex(16'shAAAA, 16'sh5555, 16'shEDCB);
        drain();
    endtask

    // Largest radii near the vertex: clipped terms and saturated sums
    task automatic test_saturation;
        set_balls(0, 0, 0, 24'hFFFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 24'hFFFFFF);
        send_vertex(16'sd0, 16'sd0, 16'sd0);
        send_vertex(16'sd1, 16'sd0, 16'sd0);
        send_vertex(16'sd0, -16'sd1, 16'sd1);
        send_vertex(16'sd200, 16'sd100, -16'sd300);
        send_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_vertex(16'sh8000, 16'sh7FFF, 16'sh8000);
        drain();
    endtask

    // Zero radii contribute nothing, then ball B's r2 is set to one
    task automatic test_zero_radius;
        set_balls(16'h8000, 16'h7FFF, 0, 0, 100, -100, 50, 0);
        send_vertex(16'sd100, -16'sd100, 16'sd50);
        send_vertex(16'sh8000, 16'sh7FFF, 16'sd0);
        send_vertex(16'sd3, 16'sd4, 16'sd5);
        drain();
        write_reg(mbf_pkg::CFG_BALL_B_R2, CDW'(1));
        send_vertex(16'sd100, -16'sd100, 16'sd50);
        send_vertex(16'sd101, -16'sd100, 16'sd50);
        drain();
    endtask

    function automatic logic [CRW-1:0] near_coord(logic signed [CRW-1:0] centre);
        return centre + CRW'($signed($urandom_range(2048)) - 1024);
    endfunction

    // Random balls and vertices under the current idling mode
    task automatic test_random_phase(int n_items);
        int sel, span;
        for (int p = 0; p < 5; p++)
        begin
            sel = $urandom_range(3);
            span = (sel == 0) ? 65535 : 4096;
            for (int b = 0; b < NB; b++)
            begin
                for (int c = 0; c < NA; c++)
                    write_reg(mbf_pkg::cfg_reg_e'(b * 4 + c),
                              CDW'($urandom_range(span) - span / 2));
                write_reg(mbf_pkg::cfg_reg_e'(b * 4 + 3),
                          CDW'((sel == 3) ? $urandom : $urandom_range(8192)));
            end
            for (int i = 0; i < n_items; i++)
            begin
                int bb;
                bb = $urandom_range(1);
                if ($urandom_range(99) < 70)
                    send_vertex(near_coord(ball_centre[bb][0]),
                                near_coord(ball_centre[bb][1]),
                                near_coord(ball_centre[bb][2]));
                else if ($urandom_range(9) == 0)
                    send_vertex(ball_centre[bb][0], ball_centre[bb][1], ball_centre[bb][2]);
                else
                    send_vertex(CRW'($urandom), CRW'($urandom), CRW'($urandom));
                if (i == n_items / 2 && $urandom_range(1) == 1)
                    drain();
            end
            drain();
        end
    endtask

    initial
    begin
        ball_centre[0][0] = -512; ball_centre[0][1] = 512; ball_centre[0][2] = 0;
        ball_r2[0] = 2304;
        ball_centre[1][0] = 512; ball_centre[1][1] = 384; ball_centre[1][2] = 0;
        ball_r2[1] = 4096;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 24; recv_idle_pct = 58;
        test_default_balls();
        test_saturation();
        test_zero_radius();
        test_random_phase(100);
        send_idle_pct = 58; recv_idle_pct = 24;
        test_random_phase(100);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random_phase(105);

        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
design/mbf_pkg.sv
design/mbf_cell.sv
design/mbf_lane.sv
design/metaball_field_and_normal.sv
dv/tb.sv
